[design/ulpf_pkg.sv]
// shared types and constants of the unique local peak finder
`timescale 1ns / 1ps

package ulpf_pkg;

	// default build sizes
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int PIXEL_BITS_DEF = 24;

	// fixed widths of the ports
	localparam int PIX_PORT_W = 24;
	localparam int PIX_EXT_W  = 32;
	localparam int DIM_W      = 11;
	localparam int TOL_W      = 24;
	localparam int POS_W      = 11;
	localparam int STATUS_W   = 2;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// first row and column that carry a full 3x3 window
	localparam int BORDER = 2;

	// register addresses
	localparam logic [APB_ADDR_W-1:0] ADDR_FRAME_WIDTH  = 4'h0;
	localparam logic [APB_ADDR_W-1:0] ADDR_FRAME_HEIGHT = 4'h4;
	localparam logic [APB_ADDR_W-1:0] ADDR_TOLERANCE    = 4'h8;

	// register reset values
	localparam logic [DIM_W-1:0] FRAME_DIM_RST = 11'd1024;
	localparam logic [TOL_W-1:0] TOLERANCE_RST = 24'd0;

	typedef enum logic [STATUS_W-1:0] {
		ST_UNIQUE = 2'd0,
		ST_NONE   = 2'd1,
		ST_MULTI  = 2'd2
	} status_t;

	// per-pixel control that travels with a request down the pipeline
	typedef struct packed {
		logic valid;
		logic interior;
		logic last;
	} ctl_t;

endpackage

[design/ulpf_line_mem.sv]
// two line stores packed in one synchronous memory, with write-to-read forwarding
`timescale 1ns / 1ps

module ulpf_line_mem
	import ulpf_pkg::*;
#(
	parameter int DEPTH     = MAX_WIDTH_DEF,
	parameter int DATA_BITS = 2 * PIXEL_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_BITS-1:0]     wr_data,
	output logic [DATA_BITS-1:0]     rd_data
);

	logic [DATA_BITS-1:0] mem [DEPTH];
	logic [DATA_BITS-1:0] rd_data_q;
	logic [DATA_BITS-1:0] fwd_data_q;
	logic                 fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		fwd_data_q <= wr_data;
	end

	// same entry read while the previous request writes it back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_data_q;

endmodule

[design/ulpf_window.sv]
// 3x3 window registers and the peak test on the window centre
`timescale 1ns / 1ps

module ulpf_window
	import ulpf_pkg::*;
#(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  shift_en,
	input  logic [PIXEL_BITS-1:0] upper,
	input  logic [PIXEL_BITS-1:0] middle,
	input  logic [PIXEL_BITS-1:0] lower,
	input  logic [TOL_W-1:0]      tolerance,
	output logic                  is_peak,
	output logic [PIXEL_BITS-1:0] centre
);

	localparam int CMP_W = (PIXEL_BITS > TOL_W) ? PIXEL_BITS : TOL_W;

	logic [PIXEL_BITS-1:0] win_q [3][3];

	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= upper;
			win_q[1][2] <= middle;
			win_q[2][2] <= lower;
		end
	end

	assign centre = win_q[1][1];

	// unsigned test: centre must be above the neighbor by more than the tolerance
	always_comb begin
		logic [PIXEL_BITS-1:0] diff;
		is_peak = 1'b1;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				diff = win_q[1][1] - win_q[i][k];
				if (!(i == 1 && k == 1)) begin
					if (!((win_q[1][1] > win_q[i][k]) &&
					      (CMP_W'(diff) > CMP_W'(tolerance)))) begin
						is_peak = 1'b0;
					end
				end
			end
		end
	end

endmodule

[design/ulpf_tracker.sv]
// peak count, first peak capture and the frame result register
`timescale 1ns / 1ps

module ulpf_tracker
	import ulpf_pkg::*;
#(
	parameter int COL_BITS   = $clog2(MAX_WIDTH_DEF),
	parameter int ROW_BITS   = $clog2(MAX_HEIGHT_DEF),
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_t                  ctl,
	input  logic                  is_peak,
	input  logic [PIXEL_BITS-1:0] centre,
	input  logic [COL_BITS-1:0]   col,
	input  logic [ROW_BITS-1:0]   row,
	input  logic                  result_stall,
	output logic                  result_valid,
	output logic [STATUS_W-1:0]   status,
	output logic [POS_W-1:0]      peak_column,
	output logic [POS_W-1:0]      peak_row,
	output logic [PIX_PORT_W-1:0] peak_value
);

	logic                  have_q;
	logic                  multi_q;
	logic [COL_BITS-1:0]   found_col_q;
	logic [ROW_BITS-1:0]   found_row_q;
	logic [PIXEL_BITS-1:0] found_val_q;

	logic                  valid_q;
	status_t               status_q;
	logic [POS_W-1:0]      col_q;
	logic [POS_W-1:0]      row_q;
	logic [PIX_PORT_W-1:0] value_q;

	logic                  peak;
	logic                  capture;
	logic                  have_n;
	logic                  multi_n;
	logic [COL_BITS-1:0]   col_n;
	logic [ROW_BITS-1:0]   row_n;
	logic [PIXEL_BITS-1:0] val_n;
	logic [PIX_EXT_W-1:0]  val_ext;
	logic                  frame_end;

	always_comb begin
		peak      = ctl.valid && ctl.interior && is_peak;
		capture   = peak && !have_q;
		have_n    = have_q || peak;
		multi_n   = multi_q || (peak && have_q);
		// the window centre sits one column and one row back, so 1-based it is col, row
		col_n     = capture ? col : found_col_q;
		row_n     = capture ? row : found_row_q;
		val_n     = capture ? centre : found_val_q;
		val_ext   = PIX_EXT_W'(val_n);
		frame_end = ctl.valid && ctl.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			multi_q <= 1'b0;
		end else if (frame_end) begin
			have_q  <= 1'b0;
			multi_q <= 1'b0;
		end else if (ctl.valid) begin
			have_q  <= have_n;
			multi_q <= multi_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_col_q <= '0;
			found_row_q <= '0;
			found_val_q <= '0;
		end else if (frame_end) begin
			found_col_q <= '0;
			found_row_q <= '0;
			found_val_q <= '0;
		end else if (capture) begin
			found_col_q <= col_n;
			found_row_q <= row_n;
			found_val_q <= val_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (frame_end) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_end) begin
			if (have_n && !multi_n) begin
				status_q <= ST_UNIQUE;
				col_q    <= POS_W'(col_n);
				row_q    <= POS_W'(row_n);
				value_q  <= val_ext[PIX_PORT_W-1:0];
			end else begin
				status_q <= multi_n ? ST_MULTI : ST_NONE;
				col_q    <= '0;
				row_q    <= '0;
				value_q  <= '0;
			end
		end
	end

	assign result_valid = valid_q;
	assign status       = status_q;
	assign peak_column  = col_q;
	assign peak_row     = row_q;
	assign peak_value   = value_q;

endmodule

[design/unique_local_peak_finder_unit.sv]
// top level of the unique local peak finder: register port, raster counters, pipeline
`timescale 1ns / 1ps

// Pixels enter in raster order at one per clock unless pixel_stall holds them. Each
// pixel reads both line stores in the cycle it is accepted, writes them back the
// next cycle (a one-entry forward covers frames one pixel wide), shifts the 3x3
// window, and is peak-tested in the cycle after that; the frame result is registered
// once the frame's last pixel has passed ctl_s1 and ctl_s2. One frame result may
// be held or in flight at a time, so the last pixel of a frame waits while the
// previous frame's result is still undelivered; with no result stall, frames too
// short to cover that wait run below one pixel per clock and larger frames run at
// one pixel per clock. The line stores are one memory of MAX_WIDTH entries of two
// pixels and need no clearing pass after reset.
module unique_local_peak_finder_unit
	import ulpf_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// pixel requests
	input  logic                  pixel_valid,
	output logic                  pixel_stall,
	input  logic [PIX_PORT_W-1:0] pixel,
	// frame results
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [POS_W-1:0]      peak_column,
	output logic [POS_W-1:0]      peak_row,
	output logic [PIX_PORT_W-1:0] peak_value
);

	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int ROW_BITS = $clog2(MAX_HEIGHT);
	localparam int MEM_BITS = 2 * PIXEL_BITS;

	// registers
	logic [DIM_W-1:0] frame_width_q;
	logic [DIM_W-1:0] frame_height_q;
	logic [TOL_W-1:0] tolerance_q;
	logic             cfg_wr;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_DIM_RST;
			frame_height_q <= FRAME_DIM_RST;
			tolerance_q    <= TOLERANCE_RST;
		end else if (cfg_wr) begin
			unique case (paddr)
				ADDR_FRAME_WIDTH:  frame_width_q  <= pwdata[DIM_W-1:0];
				ADDR_FRAME_HEIGHT: frame_height_q <= pwdata[DIM_W-1:0];
				ADDR_TOLERANCE:    tolerance_q    <= pwdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_q);
			ADDR_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_q);
			ADDR_TOLERANCE:    prdata = APB_DATA_W'(tolerance_q);
			default:           prdata = '0;
		endcase
	end

	// effective frame size: clamp to the maximum, zero counts as one
	logic [COL_BITS:0] width_eff;
	logic [ROW_BITS:0] height_eff;

	always_comb begin
		if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			width_eff = (COL_BITS+1)'(MAX_WIDTH);
		end else if (frame_width_q == '0) begin
			width_eff = (COL_BITS+1)'(1);
		end else begin
			width_eff = (COL_BITS+1)'(frame_width_q);
		end
		if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			height_eff = (ROW_BITS+1)'(MAX_HEIGHT);
		end else if (frame_height_q == '0) begin
			height_eff = (ROW_BITS+1)'(1);
		end else begin
			height_eff = (ROW_BITS+1)'(frame_height_q);
		end
	end

	// raster position of the next pixel
	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic                row_end;
	logic                frame_last;
	logic                interior;
	logic                accept;
	logic                result_pending;

	ctl_t                  ctl_s1;
	ctl_t                  ctl_s2;
	logic [COL_BITS-1:0]   col_s1;
	logic [ROW_BITS-1:0]   row_s1;
	logic [PIXEL_BITS-1:0] px_s1;
	logic [COL_BITS-1:0]   col_s2;
	logic [ROW_BITS-1:0]   row_s2;

	assign row_end    = ((COL_BITS+1)'(col_q) + (COL_BITS+1)'(1)) >= width_eff;
	assign frame_last = row_end &&
	                    (((ROW_BITS+1)'(row_q) + (ROW_BITS+1)'(1)) >= height_eff);
	assign interior   = (32'(col_q) >= 32'(BORDER)) && (32'(row_q) >= 32'(BORDER));

	// only one frame result may be held or in flight
	assign result_pending = (ctl_s1.valid && ctl_s1.last) ||
	                        (ctl_s2.valid && ctl_s2.last) || result_valid;
	assign pixel_stall    = frame_last && result_pending;
	assign accept         = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_last ? '0 : ROW_BITS'(row_q + ROW_BITS'(1));
			end else begin
				col_q <= COL_BITS'(col_q + COL_BITS'(1));
			end
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1.valid    <= accept;
			ctl_s1.interior <= interior;
			ctl_s1.last     <= frame_last;
			ctl_s2          <= ctl_s1;
		end
	end

	logic [PIX_EXT_W-1:0] pixel_ext;

	assign pixel_ext = PIX_EXT_W'(pixel);

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= col_q;
			row_s1 <= row_q;
			px_s1  <= pixel_ext[PIXEL_BITS-1:0];
		end
		if (ctl_s1.valid) begin
			col_s2 <= col_s1;
			row_s2 <= row_s1;
		end
	end

	// line stores: upper half is the row two back, lower half the row before
	logic [MEM_BITS-1:0]   mem_rd;
	logic [MEM_BITS-1:0]   mem_wr;
	logic [PIXEL_BITS-1:0] upper_rd;
	logic [PIXEL_BITS-1:0] middle_rd;

	assign upper_rd  = mem_rd[MEM_BITS-1:PIXEL_BITS];
	assign middle_rd = mem_rd[PIXEL_BITS-1:0];
	assign mem_wr    = {middle_rd, px_s1};

	ulpf_line_mem #(
		.DEPTH     (MAX_WIDTH),
		.DATA_BITS (MEM_BITS)
	) u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_q),
		.wr_en   (ctl_s1.valid),
		.wr_addr (col_s1),
		.wr_data (mem_wr),
		.rd_data (mem_rd)
	);

	logic                  is_peak;
	logic [PIXEL_BITS-1:0] centre;

	ulpf_window #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_window (
		.clk       (clk),
		.shift_en  (ctl_s1.valid),
		.upper     (upper_rd),
		.middle    (middle_rd),
		.lower     (px_s1),
		.tolerance (tolerance_q),
		.is_peak   (is_peak),
		.centre    (centre)
	);

	ulpf_tracker #(
		.COL_BITS   (COL_BITS),
		.ROW_BITS   (ROW_BITS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl_s2),
		.is_peak      (is_peak),
		.centre       (centre),
		.col          (col_s2),
		.row          (row_s2),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.status       (status),
		.peak_column  (peak_column),
		.peak_row     (peak_row),
		.peak_value   (peak_value)
	);

	// at most one frame result between the last pixel and the output
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl_s1.valid && ctl_s1.last, ctl_s2.valid && ctl_s2.last, result_valid}))
		else $error("more than one frame result in flight");

	// a new result only follows the last pixel of a frame
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(ctl_s2.valid && ctl_s2.last))
		else $error("result without a frame end");

	// no unique peak means all position and value fields are zero
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_UNIQUE) |->
			(peak_column == '0) && (peak_row == '0) && (peak_value == '0))
		else $error("nonzero peak fields without a unique peak");

endmodule

[tb/sv/unique_local_peak_finder_unit_tb.sv]
// self-checking testbench of the unique local peak finder: raster frames in, frame verdicts out
`timescale 1ns / 1ps

module unique_local_peak_finder_unit_tb;
	import ulpf_pkg::*;

	// predicts the per-frame verdict and checks delivered results against it
	class peak_scoreboard;
		typedef struct {
			status_t                status;
			logic [POS_W-1:0]       column;
			logic [POS_W-1:0]       row;
			logic [PIX_PORT_W-1:0]  value;
		} frame_result_t;

		frame_result_t          pending_frames[$];
		logic [DIM_W-1:0]       width_reg  = FRAME_DIM_RST;
		logic [DIM_W-1:0]       height_reg = FRAME_DIM_RST;
		logic [TOL_W-1:0]       tol_reg    = TOLERANCE_RST;
		logic [PIX_PORT_W-1:0]  upper_line[MAX_WIDTH_DEF]  = '{default: '0};
		logic [PIX_PORT_W-1:0]  middle_line[MAX_WIDTH_DEF] = '{default: '0};
		logic [PIX_PORT_W-1:0]  window[3][3] = '{default: '0};
		int                     col_pos;
		int                     row_pos;
		int                     peak_count;
		int                     first_col;
		int                     first_row;
		logic [PIX_PORT_W-1:0]  first_value;
		int                     failures;

		function int cols();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
			return width_reg;
		endfunction

		function int rows();
			if (height_reg == 0) return 1;
			if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
			return height_reg;
		endfunction

		function void mismatch(string msg);
			failures++;
			if (failures <= 10) $display("mismatch: %s", msg);
		endfunction

		// signed test: center minus every neighbor must exceed the tolerance
		function bit centre_stands_out();
			longint centre;
			int r, k;
			centre = longint'(window[1][1]);
			for (r = 0; r < 3; r++)
				for (k = 0; k < 3; k++) begin
					if (r == 1 && k == 1) continue;
					if (!(centre - longint'(window[r][k]) > longint'(tol_reg))) return 0;
				end
			return 1;
		endfunction

		function void take_pixel(logic [PIX_PORT_W-1:0] px);
			int w, h, i;
			frame_result_t res;
			w = cols();
			h = rows();
			for (i = 0; i < 3; i++) begin
				window[i][0] = window[i][1];
				window[i][1] = window[i][2];
			end
			window[0][2] = upper_line[col_pos];
			window[1][2] = middle_line[col_pos];
			window[2][2] = px;
			upper_line[col_pos] = middle_line[col_pos];
			middle_line[col_pos] = px;
			if (row_pos >= 2 && col_pos >= 2 && centre_stands_out()) begin
				if (peak_count == 0) begin
					first_col = col_pos - 1;
					first_row = row_pos - 1;
					first_value = window[1][1];
					peak_count = 1;
				end else begin
					peak_count = 2;
				end
			end
			if (col_pos + 1 >= w) begin
				col_pos = 0;
				if (row_pos + 1 >= h) begin
					if (peak_count == 1) begin
						res.status = ST_UNIQUE;
						res.column = POS_W'(first_col + 1);
						res.row = POS_W'(first_row + 1);
						res.value = first_value;
					end else begin
						res.status = (peak_count == 0) ? ST_NONE : ST_MULTI;
						res.column = '0;
						res.row = '0;
						res.value = '0;
					end
					pending_frames.push_back(res);
					row_pos = 0;
					peak_count = 0;
					first_col = 0;
					first_row = 0;
					first_value = '0;
				end else begin
					row_pos++;
				end
			end else begin
				col_pos++;
			end
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [POS_W-1:0] c,
				logic [POS_W-1:0] r, logic [PIX_PORT_W-1:0] v);
			frame_result_t want;
			if (pending_frames.size() == 0) begin
				mismatch($sformatf("unexpected result status %0d col %0d row %0d value %0h",
					st, c, r, v));
				return;
			end
			want = pending_frames.pop_front();
			if (st !== want.status || c !== want.column || r !== want.row || v !== want.value)
				mismatch($sformatf(
					"expected status %0d col %0d row %0d value %0h, got %0d %0d %0d %0h",
					want.status, want.column, want.row, want.value, st, c, r, v));
		endfunction
	endclass

	typedef enum {FR_NOISE, FR_FLAT, FR_PLANT, FR_EXTREME, FR_NEAR_MISS} frame_kind_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  pixel_valid = 1'b0;
	logic                  pixel_stall;
	logic [PIX_PORT_W-1:0] pixel = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [POS_W-1:0]      peak_column;
	logic [POS_W-1:0]      peak_row;
	logic [PIX_PORT_W-1:0] peak_value;

	peak_scoreboard sb;
	int  burst_left = 0;
	int  pixels_sent = 0;
	bit  hold_off_req = 0;

	unique_local_peak_finder_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.peak_column  (peak_column),
		.peak_row     (peak_row),
		.peak_value   (peak_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("unique_local_peak_finder_unit verification failed");
		$finish;
	end

	// result side: checks delivered verdicts and stalls on a pattern of its own
	initial begin
		int stall_mode, mode_left, hold_left;
		stall_mode = 0;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall)
				sb.check_result(status, peak_column, peak_row, peak_value);
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (hold_off_req) begin
				hold_off_req = 0;
				hold_left = 300;
				result_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(5, 60);
				end
				mode_left--;
				case (stall_mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 1) == 0);
					default: result_stall <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_pixel(input logic [PIX_PORT_W-1:0] px);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(40, 200);
			end else begin
				pixel_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
		end
		pixel_valid <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		sb.take_pixel(px);
		pixels_sent++;
		burst_left--;
	endtask

	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	// registers change only with every frame verdict delivered and the pipe empty
	task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input logic [TOL_W-1:0] tol);
		logic [APB_DATA_W-1:0] junk;
		pixel_valid <= 1'b0;
		while (sb.pending_frames.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		junk = $urandom;
		write_reg(ADDR_FRAME_WIDTH, {junk[APB_DATA_W-1:DIM_W], w});
		write_reg(ADDR_FRAME_HEIGHT, {junk[APB_DATA_W-1:DIM_W], h});
		write_reg(ADDR_TOLERANCE, {junk[APB_DATA_W-1:TOL_W], tol});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.width_reg = w;
		sb.height_reg = h;
		sb.tol_reg = tol;
	endtask

	task automatic run_frame(input frame_kind_e kind, input int npeaks);
		int w, h, bg_max, pc, pr, dr, dc, k;
		longint s;
		logic [PIX_PORT_W-1:0] top, flat_val;
		logic [PIX_PORT_W-1:0] pix[];
		w = sb.cols();
		h = sb.rows();
		pix = new[w * h];
		bg_max = (1 << $urandom_range(0, 23)) - 1;
		flat_val = PIX_PORT_W'($urandom);
		foreach (pix[i]) begin
			case (kind)
				FR_NOISE:   pix[i] = PIX_PORT_W'($urandom);
				FR_FLAT:    pix[i] = flat_val;
				FR_EXTREME: pix[i] = '0;
				default:    pix[i] = PIX_PORT_W'($urandom_range(0, bg_max));
			endcase
		end
		if (kind == FR_EXTREME) begin
			top = '1;
		end else begin
			s = longint'(bg_max) + longint'(sb.tol_reg) + 1 + $urandom_range(0, 255);
			top = (s > 64'hFFFFFF) ? '1 : s[PIX_PORT_W-1:0];
		end
		if ((kind == FR_PLANT || kind == FR_EXTREME || kind == FR_NEAR_MISS) &&
				w >= 3 && h >= 3) begin
			pc = 1;
			pr = 1;
			for (k = 0; k < npeaks; k++) begin
				pc = $urandom_range(1, w - 2);
				pr = $urandom_range(1, h - 2);
				pix[pr * w + pc] = top;
			end
			// one neighbor exactly tolerance below the center: must not count as a peak
			if (kind == FR_NEAR_MISS) begin
				do begin
					dr = $urandom_range(0, 2) - 1;
					dc = $urandom_range(0, 2) - 1;
				end while (dr == 0 && dc == 0);
				pix[(pr + dr) * w + pc + dc] = (top >= sb.tol_reg) ? top - sb.tol_reg : top;
			end
		end
		foreach (pix[i]) send_pixel(pix[i]);
	endtask

	initial begin
		int start_count, guard, n, r;
		frame_kind_e kind;
		logic [DIM_W-1:0] w, h;
		logic [TOL_W-1:0] tol;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames
		set_geometry(3, 3, 0);
		run_frame(FR_EXTREME, 1);
		run_frame(FR_FLAT, 0);
		run_frame(FR_NEAR_MISS, 1);
		set_geometry(0, 0, '1);
		run_frame(FR_NOISE, 0);
		run_frame(FR_NOISE, 0);
		set_geometry(5, 5, 24'hFFFFFE);
		run_frame(FR_EXTREME, 2);
		set_geometry(5, 5, '1);
		run_frame(FR_EXTREME, 1);

		// result side holds off while single-pixel frames keep coming
		set_geometry(1, 1, 0);
		hold_off_req = 1;
		repeat (40) run_frame(FR_NOISE, 0);

		// random geometries and frame contents
		start_count = pixels_sent;
		while (pixels_sent - start_count < 480) begin
			r = $urandom_range(0, 9);
			w = (r == 0) ? 0 : (r == 1) ? DIM_W'($urandom_range(1, 2)) :
				DIM_W'($urandom_range(3, 8));
			r = $urandom_range(0, 9);
			h = (r == 0) ? 0 : (r == 1) ? DIM_W'($urandom_range(1, 2)) :
				DIM_W'($urandom_range(3, 8));
			case ($urandom_range(0, 4))
				0: tol = '0;
				1: tol = TOL_W'($urandom_range(1, 15));
				2: tol = TOL_W'($urandom);
				3: tol = '1;
				default: tol = TOL_W'($urandom_range(0, 4095));
			endcase
			set_geometry(w, h, tol);
			n = $urandom_range(1, 4);
			repeat (n) begin
				r = $urandom_range(0, 19);
				kind = (r < 10) ? FR_PLANT : (r < 12) ? FR_EXTREME : (r < 15) ? FR_NEAR_MISS :
					(r < 18) ? FR_NOISE : FR_FLAT;
				run_frame(kind, $urandom_range(0, 3));
			end
		end

		pixel_valid <= 1'b0;
		guard = 0;
		while (sb.pending_frames.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (sb.pending_frames.size() != 0)
			sb.mismatch($sformatf("%0d frame results never arrived", sb.pending_frames.size()));
		if (sb.failures == 0) begin
			$display("unique_local_peak_finder_unit verification clean");
		end else begin
			$display("unique_local_peak_finder_unit verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
design/ulpf_pkg.sv
design/ulpf_line_mem.sv
design/ulpf_window.sv
design/ulpf_tracker.sv
design/unique_local_peak_finder_unit.sv
tb/sv/unique_local_peak_finder_unit_tb.sv
